/* rtl/core/tksd_pkg.sv */
// Shared types, codes and keypad tables for the terminal key sequence decoder.
package tksd_pkg;

    typedef logic [6:0] t_char;
    typedef logic [6:0] t_cmd;
    typedef logic [1:0] t_kind;

    // Result kinds
    localparam t_kind KIND_CHAR = 2'd0;
    localparam t_kind KIND_CMD  = 2'd1;
    localparam t_kind KIND_RAW  = 2'd2;

    // Editor command numbers
    localparam t_cmd CMD_BACKSPACE = 7'd0;
    localparam t_cmd CMD_UP        = 7'd1;
    localparam t_cmd CMD_DOWN      = 7'd2;
    localparam t_cmd CMD_RIGHT     = 7'd3;
    localparam t_cmd CMD_LEFT      = 7'd4;
    localparam t_cmd CMD_UNAS      = 7'd5;
    localparam t_cmd CMD_DELCH     = 7'd6;
    localparam t_cmd CMD_INSMODE   = 7'd7;
    localparam t_cmd CMD_MSRCH     = 7'd8;
    localparam t_cmd CMD_PSRCH     = 7'd9;
    localparam t_cmd CMD_MARK      = 7'd10;
    localparam t_cmd CMD_MPAGE     = 7'd11;
    localparam t_cmd CMD_PPAGE     = 7'd12;
    localparam t_cmd CMD_PICK      = 7'd13;
    localparam t_cmd CMD_MLINE     = 7'd14;
    localparam t_cmd CMD_PLINE     = 7'd15;
    localparam t_cmd CMD_SETFILE   = 7'd16;
    localparam t_cmd CMD_COMMAND   = 7'd17;
    localparam t_cmd CMD_CLOSE     = 7'd18;
    localparam t_cmd CMD_OPEN      = 7'd19;
    localparam t_cmd CMD_SPLIT     = 7'd20;
    localparam t_cmd CMD_CQUOTE    = 7'd21;
    localparam t_cmd CMD_ERASE     = 7'd22;
    localparam t_cmd CMD_LWIN      = 7'd23;
    localparam t_cmd CMD_JOIN      = 7'd24;
    localparam t_cmd CMD_RWIN      = 7'd25;
    localparam t_cmd CMD_DWORD     = 7'd26;
    localparam t_cmd CMD_PLAY      = 7'd27;
    localparam t_cmd CMD_RECORD    = 7'd28;
    localparam t_cmd CMD_REPLACE   = 7'd29;
    localparam t_cmd CMD_TABS      = 7'd30;
    localparam t_cmd CMD_BTAB      = 7'd31;
    localparam t_cmd CMD_CHWIN     = 7'd32;

    // Character codes
    localparam t_char CH_DEL      = 7'h7F;
    localparam t_char CH_SPACE    = 7'h20;
    localparam t_char CH_ESC      = 7'h1B;
    localparam t_char CH_LBRACKET = 7'h5B;
    localparam t_char CH_UPPER_O  = 7'h4F;
    localparam t_char CH_UPPER_A  = 7'h41;
    localparam t_char CH_UPPER_B  = 7'h42;
    localparam t_char CH_UPPER_C  = 7'h43;
    localparam t_char CH_UPPER_D  = 7'h44;
    localparam t_char CH_UPPER_M  = 7'h4D;
    localparam t_char CH_UPPER_S  = 7'h53;
    localparam t_char CH_LOWER_L  = 7'h6C;
    localparam t_char CH_LOWER_Y  = 7'h79;

    // Control characters
    localparam t_char CTL_A = 7'd1;
    localparam t_char CTL_B = 7'd2;
    localparam t_char CTL_C = 7'd3;
    localparam t_char CTL_E = 7'd5;
    localparam t_char CTL_H = 7'd8;
    localparam t_char CTL_J = 7'd10;
    localparam t_char CTL_L = 7'd12;
    localparam t_char CTL_N = 7'd14;
    localparam t_char CTL_P = 7'd16;
    localparam t_char CTL_R = 7'd18;
    localparam t_char CTL_T = 7'd20;
    localparam t_char CTL_U = 7'd21;
    localparam t_char CTL_W = 7'd23;
    localparam t_char CTL_X = 7'd24;

    // Keypad tables: ESC O l..y and ESC O M..S
    localparam t_cmd PAD_LOWER [0:13] = '{
        CMD_DOWN, CMD_UP, CMD_DELCH, CMD_UNAS, CMD_INSMODE, CMD_MSRCH, CMD_PSRCH,
        CMD_MARK, CMD_MPAGE, CMD_PPAGE, CMD_PICK, CMD_MLINE, CMD_PLINE, CMD_SETFILE
    };
    localparam t_cmd PAD_UPPER [0:6] = '{
        CMD_COMMAND, CMD_UNAS, CMD_UNAS, CMD_CLOSE, CMD_OPEN, CMD_LEFT, CMD_RIGHT
    };

    function automatic t_cmd bracket_cmd(input t_char b);
        t_cmd r;
        case (b)
            CH_UPPER_A: r = CMD_UP;
            CH_UPPER_B: r = CMD_DOWN;
            CH_UPPER_C: r = CMD_RIGHT;
            CH_UPPER_D: r = CMD_LEFT;
            default:    r = CMD_UNAS;
        endcase
        return r;
    endfunction

    function automatic t_cmd ss3_cmd(input t_char b);
        t_char lo_off;
        t_char up_off;
        t_cmd  r;
        lo_off = b - CH_LOWER_L;
        up_off = b - CH_UPPER_M;
        if (b >= CH_LOWER_L && b <= CH_LOWER_Y) begin
            r = PAD_LOWER[lo_off[3:0]];
        end else if (b >= CH_UPPER_M && b <= CH_UPPER_S) begin
            r = PAD_UPPER[up_off[2:0]];
        end else begin
            r = CMD_UNAS;
        end
        return r;
    endfunction

    function automatic t_cmd ctlx_cmd(input t_char b, input logic rec);
        t_cmd r;
        case (b)
            CTL_A:   r = CMD_SETFILE;
            CTL_B:   r = CMD_SPLIT;
            CTL_C:   r = CMD_CQUOTE;
            CTL_E:   r = CMD_ERASE;
            CTL_H:   r = CMD_LWIN;
            CTL_J:   r = CMD_JOIN;
            CTL_L:   r = CMD_RWIN;
            CTL_N:   r = CMD_DWORD;
            CTL_P:   r = rec ? CMD_PLAY : CMD_UNAS;
            CTL_R:   r = rec ? CMD_RECORD : CMD_REPLACE;
            CTL_T:   r = CMD_TABS;
            CTL_U:   r = CMD_BTAB;
            CTL_W:   r = CMD_CHWIN;
            default: r = CMD_UNAS;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/terminal_key_sequence_decoder_top.sv */
// Top level of the terminal key sequence decoder: parser state and result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_key_byte) carries one keyboard
//   word per handshake; bit 7 is ignored. Output channel (o_out_valid /
//   i_out_stall / o_out_kind / o_out_value) carries at most one result word
//   per input word: kind 0 printable char, 1 editor command, 2 raw control.
//   Prefix words (ESC, ESC [, ESC O, ctrl-X) only advance the parser and
//   produce no output word.
//   Result: a result is registered into the output register as its input
//   word is accepted. Throughput: one input word per cycle while o_in_stall
//   is low; the decode is a small next-state/table lookup between the parser
//   state register and the output register.
//   Stall: while the output register holds a word and i_out_stall is high,
//   o_in_stall is raised; the held word stays stable until taken. An input
//   word that yields no result still waits for the stall to clear.
//   Config: i_cfg_wr_en writes i_cfg_wr_data to the recording-enable bit;
//   write it only while idle. It is sampled when a ctrl-X sequence ends.
//   Reset (i_rst_n low, synchronous): parser idle, output empty, recording
//   disabled.
module terminal_key_sequence_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_key_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tksd_pkg::t_kind      o_out_kind,
    output tksd_pkg::t_cmd       o_out_value
);
    import tksd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ESC,
        ST_BRACKET,
        ST_SS3,
        ST_CTLX
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_rec;
    logic   r_out_valid;
    t_kind  r_out_kind;
    t_cmd   r_out_value;

    t_char  w_b;
    logic   w_in_acc;
    logic   w_res;
    t_kind  w_kind;
    t_cmd   w_val;

    assign w_b        = i_key_byte[6:0];
    // Input is held back only when a finished word is stuck at the output.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    always_comb begin
        n_state = ST_IDLE;
        w_res   = 1'b1;
        w_kind  = KIND_CMD;
        w_val   = CMD_UNAS;
        case (r_state)
            ST_ESC: begin
                if (w_b == CH_LBRACKET) begin
                    n_state = ST_BRACKET;
                    w_res   = 1'b0;
                end else if (w_b == CH_UPPER_O) begin
                    n_state = ST_SS3;
                    w_res   = 1'b0;
                end
            end
            ST_BRACKET: w_val = bracket_cmd(w_b);
            ST_SS3:     w_val = ss3_cmd(w_b);
            ST_CTLX:    w_val = ctlx_cmd(w_b, r_rec);
            default: begin
                // idle (unused codes land here too)
                if (w_b == CH_DEL) begin
                    w_val = CMD_BACKSPACE;
                end else if (w_b >= CH_SPACE) begin
                    w_kind = KIND_CHAR;
                    w_val  = w_b;
                end else if (w_b == CH_ESC) begin
                    n_state = ST_ESC;
                    w_res   = 1'b0;
                end else if (w_b == CTL_X) begin
                    n_state = ST_CTLX;
                    w_res   = 1'b0;
                end else if (w_b == CTL_H) begin
                    w_val = CMD_BACKSPACE;
                end else if (w_b == CTL_C) begin
                    w_val = CMD_LEFT;
                end else begin
                    w_kind = KIND_RAW;
                    w_val  = w_b;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rec       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rec <= i_cfg_wr_data;
            end
            if (w_in_acc) begin
                r_state <= n_state;
            end
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= w_in_acc & w_res;
            end
        end
    end

    // Payload register, loaded only with a real result
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_res) begin
            r_out_kind  <= w_kind;
            r_out_value <= w_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_value = r_out_value;

    // ESC taken while idle opens an escape sequence and yields nothing.
    a_esc_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_state == ST_IDLE && w_b == CH_ESC)
        |=> (r_state == ST_ESC && !(o_out_valid && !$past(o_out_valid))))
        else $error("ESC prefix did not enter escape state silently");

    // Any final byte of a bracket, keypad or ctrl-X sequence returns to idle.
    a_seq_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_state == ST_BRACKET || r_state == ST_SS3 || r_state == ST_CTLX))
        |=> (r_state == ST_IDLE && o_out_valid && o_out_kind == KIND_CMD))
        else $error("sequence end did not produce a command");

    // Printable results are never below space; kind code 3 never appears.
    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_kind != 2'd3 &&
                         (o_out_kind != KIND_CHAR || o_out_value >= CH_SPACE)))
        else $error("bad output kind/value");

    // Commands stay in the defined range.
    a_cmd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_kind == KIND_CMD) |-> (o_out_value <= CMD_CHWIN))
        else $error("command number out of range");

endmodule
